// ----- hdl/dpmb_pkg.sv -----
// Shared types and constants for the dual-port mailbox FIFO block.
package dpmb_pkg;

  localparam int UP_FIFO_DEPTH_DEF = 24;

  typedef enum logic [1:0] {
    OP_HOST_RD = 2'd0,
    OP_HOST_WR = 2'd1,
    OP_PARA_RD = 2'd2,
    OP_PARA_WR = 2'd3
  } op_t;

  // Register offsets within the eight-register window
  localparam logic [2:0] REG_CH1_STAT = 3'd0;
  localparam logic [2:0] REG_CH1_DATA = 3'd1;
  localparam logic [2:0] REG_CH2_STAT = 3'd2;
  localparam logic [2:0] REG_CH2_DATA = 3'd3;
  localparam logic [2:0] REG_CH3_STAT = 3'd4;
  localparam logic [2:0] REG_CH3_DATA = 3'd5;
  localparam logic [2:0] REG_CH4_STAT = 3'd6;
  localparam logic [2:0] REG_CH4_DATA = 3'd7;
  localparam logic [2:0] REG_SELECT   = 3'd6;

  // Control latch bit positions; T and S exist only in the written byte
  localparam int CB_Q = 0;
  localparam int CB_I = 1;
  localparam int CB_J = 2;
  localparam int CB_M = 3;
  localparam int CB_V = 4;
  localparam int CB_P = 5;
  localparam int CB_T = 6;
  localparam int CB_S = 7;

  // Flag pair per channel: data available and space free
  localparam int FB_SPACE = 0;
  localparam int FB_DATA  = 1;

  typedef logic [3:0][1:0] flags_t;

  localparam flags_t HOST_FLAGS_RST = 8'b01_11_01_01;
  localparam flags_t PARA_FLAGS_RST = 8'b01_00_01_01;

  // Parasite status registers of channels 2 to 4 read with these low bits set
  localparam logic [5:0] PARA_LOW_BITS = 6'h3F;
  localparam logic [7:0] DESEL_READ    = 8'hFE;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one_left;
    logic one_free;
  } fifo_sts_t;

endpackage

// ----- hdl/dpmb_up_fifo.sv -----
// Parasite-to-host channel 1 FIFO with registered head data.
module dpmb_up_fifo import dpmb_pkg::*; #(
  parameter int DEPTH = UP_FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_ctl_t  ctl,
  input  logic [7:0] wdata,
  output logic [7:0] rdata,
  output fifo_sts_t  sts
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  logic [7:0]       mem [DEPTH];
  logic [7:0]       head_data_r;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    priority if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
      cnt_nxt  = '0;
    end else if (ctl.pop) begin
      head_nxt = (head_r == LAST_PTR) ? '0 : head_r + PTR_W'(1);
      cnt_nxt  = cnt_r - ONE_CNT;
    end else if (ctl.push) begin
      tail_nxt = (tail_r == LAST_PTR) ? '0 : tail_r + PTR_W'(1);
      cnt_nxt  = cnt_r + ONE_CNT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Keep the entry at the head ready; forward a byte written at the new head
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= wdata;
    end
    head_data_r <= (ctl.push && tail_r == head_nxt) ? wdata : mem[head_nxt];
  end

  assign rdata        = head_data_r;
  assign sts.empty    = (cnt_r == '0);
  assign sts.full     = (cnt_r == FULL_CNT);
  assign sts.one_left = (cnt_r == ONE_CNT);
  assign sts.one_free = (cnt_r == FULL_CNT - ONE_CNT);

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("fifo count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !sts.full)
    else $error("push into full fifo");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> sts.empty)
    else $error("fifo not empty after clear");
`endif

endmodule

// ----- hdl/dual_port_mailbox_fifo_ula.sv -----
// Dual-port mailbox: register access decode, channel state and result stage.
// Pipeline: an item passes from the input register to the result register (2 registers deep).
// Throughput: one item per cycle while out_stall is low; channel state updates as the item leaves the input register.
// Reset (rst_n low, synchronous): channels empty, flags at idle values, control latch clear,
// device selected. FIFO storage is not cleared; only entries held are ever read.
module dual_port_mailbox_fifo_ula import dpmb_pkg::*; #(
  parameter int UP_FIFO_DEPTH = UP_FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [2:0] in_reg_index,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_host_irq,
  output logic       out_parasite_irq,
  output logic       out_parasite_nmi_pulse,
  output logic       out_parasite_reset_pulse,
  output logic       out_parasite_hold
);

  // Input register
  logic       a_valid_r;
  op_t        a_op_r;
  logic [2:0] a_reg_r;
  logic [7:0] a_data_r;
  logic       a_fire;

  // Result register
  logic       out_valid_r;
  logic [7:0] out_read_data_r;
  logic       out_host_irq_r, out_para_irq_r, out_nmi_r, out_rst_r, out_hold_r;

  // Channel state
  logic [7:0] dl1_r, dl1_nxt, dl2_r, dl2_nxt, dl4_r, dl4_nxt;
  logic [7:0] ul2_r, ul2_nxt, ul4_r, ul4_nxt;
  logic [7:0] up_p0_r, up_p0_nxt, up_p1_r, up_p1_nxt;
  logic [7:0] dn_p0_r, dn_p0_nxt, dn_p1_r, dn_p1_nxt;
  logic [1:0] up_cnt_r, up_cnt_nxt, dn_cnt_r, dn_cnt_nxt;
  flags_t     hf_r, hf_nxt, pf_r, pf_nxt;
  logic [5:0] ctrl_r, ctrl_nxt;
  logic [7:0] last_host_r, last_host_nxt, last_para_r, last_para_nxt;
  logic       nmi_level_r, nmi_level_nxt;
  logic       selected_r, selected_nxt;

  // Per-item results
  logic [7:0] rd_c;
  logic       rst_pulse_c, nmi_pulse_c, touched_c, clr_c, nmi_now_c, nmi_base_c;
  logic       push_c, pop_c;

  fifo_ctl_t  fifo_ctl;
  fifo_sts_t  fifo_sts;
  logic [7:0] fifo_rdata;

  dpmb_up_fifo #(
    .DEPTH (UP_FIFO_DEPTH)
  ) u_up_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fifo_ctl),
    .wdata (a_data_r),
    .rdata (fifo_rdata),
    .sts   (fifo_sts)
  );

  assign a_fire   = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = a_valid_r && out_valid_r && out_stall;

  assign fifo_ctl.push  = a_fire && push_c;
  assign fifo_ctl.pop   = a_fire && pop_c;
  assign fifo_ctl.clear = a_fire && clr_c;

  always_comb begin
    dl1_nxt       = dl1_r;
    dl2_nxt       = dl2_r;
    dl4_nxt       = dl4_r;
    ul2_nxt       = ul2_r;
    ul4_nxt       = ul4_r;
    up_p0_nxt     = up_p0_r;
    up_p1_nxt     = up_p1_r;
    dn_p0_nxt     = dn_p0_r;
    dn_p1_nxt     = dn_p1_r;
    up_cnt_nxt    = up_cnt_r;
    dn_cnt_nxt    = dn_cnt_r;
    hf_nxt        = hf_r;
    pf_nxt        = pf_r;
    ctrl_nxt      = ctrl_r;
    last_host_nxt = last_host_r;
    last_para_nxt = last_para_r;
    selected_nxt  = selected_r;
    rd_c          = '0;
    rst_pulse_c   = 1'b0;
    touched_c     = 1'b1;
    clr_c         = 1'b0;
    push_c        = 1'b0;
    pop_c         = 1'b0;

    unique case (a_op_r)
      OP_HOST_RD: begin
        if (!selected_r) begin
          rd_c      = DESEL_READ;
          touched_c = 1'b0;
        end else begin
          unique case (a_reg_r)
            REG_CH1_STAT: rd_c = {hf_r[0], ctrl_r};
            REG_CH1_DATA: begin
              if (!fifo_sts.empty) begin
                rd_c  = fifo_rdata;
                pop_c = 1'b1;
                if (fifo_sts.one_left) hf_nxt[0][FB_DATA] = 1'b0;
                pf_nxt[0][FB_SPACE] = 1'b1;
              end else begin
                rd_c = last_para_r;
              end
            end
            REG_CH2_STAT: rd_c = {hf_r[1], 6'b0};
            REG_CH2_DATA: begin
              rd_c = ul2_r;
              hf_nxt[1][FB_DATA]  = 1'b0;
              pf_nxt[1][FB_SPACE] = 1'b1;
            end
            REG_CH3_STAT: rd_c = {hf_r[2], 6'b0};
            REG_CH3_DATA: begin
              if (up_cnt_r != 2'd0) begin
                rd_c       = up_p0_r;
                up_p0_nxt  = up_p1_r;
                up_cnt_nxt = up_cnt_r - 2'd1;
                if (up_cnt_r == 2'd1) begin
                  hf_nxt[2][FB_DATA] = 1'b0;
                  pf_nxt[2]          = 2'b11;
                end
              end else begin
                rd_c = last_para_r;
              end
            end
            REG_CH4_STAT: rd_c = {hf_r[3], 6'b0};
            REG_CH4_DATA: begin
              rd_c = ul4_r;
              hf_nxt[3][FB_DATA]  = 1'b0;
              pf_nxt[3][FB_SPACE] = 1'b1;
            end
          endcase
        end
      end

      OP_HOST_WR: begin
        if (a_reg_r == REG_SELECT) begin
          selected_nxt = (a_data_r[7:1] == 7'd0);
          clr_c        = 1'b1;
          ctrl_nxt     = '0;
          rst_pulse_c  = (a_data_r[7:1] == 7'd0);
        end else if (!selected_r) begin
          touched_c = 1'b0;
        end else begin
          last_host_nxt = a_data_r;
          unique case (a_reg_r)
            REG_CH1_STAT: begin
              if (a_data_r[CB_S]) begin
                // T resets the channels but keeps the control latch
                clr_c    = a_data_r[CB_T];
                ctrl_nxt = ctrl_r | a_data_r[5:0];
              end else begin
                ctrl_nxt    = ctrl_r & ~a_data_r[5:0];
                rst_pulse_c = ctrl_r[CB_P] && a_data_r[CB_P];
              end
            end
            REG_CH1_DATA: begin
              dl1_nxt = a_data_r;
              pf_nxt[0][FB_DATA]  = 1'b1;
              hf_nxt[0][FB_SPACE] = 1'b0;
            end
            REG_CH2_DATA: begin
              dl2_nxt = a_data_r;
              pf_nxt[1][FB_DATA]  = 1'b1;
              hf_nxt[1][FB_SPACE] = 1'b0;
            end
            REG_CH3_DATA: begin
              if (dn_cnt_r < 2'd2) begin
                if (dn_cnt_r[0]) dn_p1_nxt = a_data_r;
                else dn_p0_nxt = a_data_r;
                dn_cnt_nxt = dn_cnt_r + 2'd1;
                if (!ctrl_r[CB_V] || dn_cnt_r[0]) begin
                  pf_nxt[2][FB_DATA]  = 1'b1;
                  hf_nxt[2][FB_SPACE] = 1'b0;
                end
              end
            end
            REG_CH4_DATA: begin
              dl4_nxt = a_data_r;
              pf_nxt[3][FB_DATA]  = 1'b1;
              hf_nxt[3][FB_SPACE] = 1'b0;
            end
            default: ;
          endcase
        end
      end

      OP_PARA_RD: begin
        unique case (a_reg_r)
          REG_CH1_STAT: rd_c = {pf_r[0], ctrl_r};
          REG_CH1_DATA: begin
            rd_c = dl1_r;
            pf_nxt[0][FB_DATA]  = 1'b0;
            hf_nxt[0][FB_SPACE] = 1'b1;
          end
          REG_CH2_STAT: rd_c = {pf_r[1], PARA_LOW_BITS};
          REG_CH2_DATA: begin
            rd_c = dl2_r;
            pf_nxt[1][FB_DATA]  = 1'b0;
            hf_nxt[1][FB_SPACE] = 1'b1;
          end
          REG_CH3_STAT: rd_c = {pf_r[2], PARA_LOW_BITS};
          REG_CH3_DATA: begin
            if (dn_cnt_r != 2'd0) begin
              rd_c       = dn_p0_r;
              dn_p0_nxt  = dn_p1_r;
              dn_cnt_nxt = dn_cnt_r - 2'd1;
              if (dn_cnt_r == 2'd1) begin
                pf_nxt[2][FB_DATA] = 1'b0;
                hf_nxt[2]          = 2'b11;
              end
            end else begin
              rd_c = last_host_r;
            end
          end
          REG_CH4_STAT: rd_c = {pf_r[3], PARA_LOW_BITS};
          REG_CH4_DATA: begin
            rd_c = dl4_r;
            pf_nxt[3][FB_DATA]  = 1'b0;
            hf_nxt[3][FB_SPACE] = 1'b1;
          end
        endcase
      end

      OP_PARA_WR: begin
        last_para_nxt = a_data_r;
        unique case (a_reg_r)
          REG_CH1_DATA: begin
            if (!fifo_sts.full) begin
              push_c = 1'b1;
              hf_nxt[0][FB_DATA] = 1'b1;
              if (fifo_sts.one_free) pf_nxt[0][FB_SPACE] = 1'b0;
            end
          end
          REG_CH2_DATA: begin
            ul2_nxt = a_data_r;
            hf_nxt[1][FB_DATA]  = 1'b1;
            pf_nxt[1][FB_SPACE] = 1'b0;
          end
          REG_CH3_DATA: begin
            if (up_cnt_r < 2'd2) begin
              if (up_cnt_r[0]) up_p1_nxt = a_data_r;
              else up_p0_nxt = a_data_r;
              up_cnt_nxt = up_cnt_r + 2'd1;
              if (!ctrl_r[CB_V] || up_cnt_r[0]) begin
                hf_nxt[2][FB_DATA] = 1'b1;
                pf_nxt[2]          = 2'b00;
              end
            end
          end
          REG_CH4_DATA: begin
            ul4_nxt = a_data_r;
            hf_nxt[3][FB_DATA]  = 1'b1;
            pf_nxt[3][FB_SPACE] = 1'b0;
          end
          default: ;
        endcase
      end
    endcase

    // Channel reset: drop everything held, last bytes too
    if (clr_c) begin
      dl1_nxt       = '0;
      dl2_nxt       = '0;
      dl4_nxt       = '0;
      ul2_nxt       = '0;
      ul4_nxt       = '0;
      up_p0_nxt     = '0;
      up_p1_nxt     = '0;
      dn_p0_nxt     = '0;
      dn_p1_nxt     = '0;
      up_cnt_nxt    = '0;
      dn_cnt_nxt    = '0;
      hf_nxt        = HOST_FLAGS_RST;
      pf_nxt        = PARA_FLAGS_RST;
      last_host_nxt = '0;
      last_para_nxt = '0;
    end

    nmi_base_c    = clr_c ? 1'b0 : nmi_level_r;
    nmi_now_c     = ctrl_nxt[CB_M] && pf_nxt[2][FB_DATA];
    nmi_pulse_c   = touched_c && nmi_now_c && !nmi_base_c;
    nmi_level_nxt = touched_c ? nmi_now_c : nmi_level_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      dl1_r       <= '0;
      dl2_r       <= '0;
      dl4_r       <= '0;
      ul2_r       <= '0;
      ul4_r       <= '0;
      up_p0_r     <= '0;
      up_p1_r     <= '0;
      dn_p0_r     <= '0;
      dn_p1_r     <= '0;
      up_cnt_r    <= '0;
      dn_cnt_r    <= '0;
      hf_r        <= HOST_FLAGS_RST;
      pf_r        <= PARA_FLAGS_RST;
      ctrl_r      <= '0;
      last_host_r <= '0;
      last_para_r <= '0;
      nmi_level_r <= 1'b0;
      selected_r  <= 1'b1;
    end else begin
      if (in_valid && !in_stall) begin
        a_valid_r <= 1'b1;
      end else if (a_fire) begin
        a_valid_r <= 1'b0;
      end
      if (a_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (a_fire) begin
        dl1_r       <= dl1_nxt;
        dl2_r       <= dl2_nxt;
        dl4_r       <= dl4_nxt;
        ul2_r       <= ul2_nxt;
        ul4_r       <= ul4_nxt;
        up_p0_r     <= up_p0_nxt;
        up_p1_r     <= up_p1_nxt;
        dn_p0_r     <= dn_p0_nxt;
        dn_p1_r     <= dn_p1_nxt;
        up_cnt_r    <= up_cnt_nxt;
        dn_cnt_r    <= dn_cnt_nxt;
        hf_r        <= hf_nxt;
        pf_r        <= pf_nxt;
        ctrl_r      <= ctrl_nxt;
        last_host_r <= last_host_nxt;
        last_para_r <= last_para_nxt;
        nmi_level_r <= nmi_level_nxt;
        selected_r  <= selected_nxt;
      end
    end
  end

  // Payload registers: input item and result item
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_op_r   <= op_t'(in_operation);
      a_reg_r  <= in_reg_index;
      a_data_r <= in_write_data;
    end
    if (a_fire) begin
      out_read_data_r <= rd_c;
      out_host_irq_r  <= ctrl_nxt[CB_Q] && hf_nxt[3][FB_DATA];
      out_para_irq_r  <= (ctrl_nxt[CB_I] && pf_nxt[0][FB_DATA]) ||
                         (ctrl_nxt[CB_J] && pf_nxt[3][FB_DATA]);
      out_nmi_r       <= nmi_pulse_c;
      out_rst_r       <= rst_pulse_c;
      out_hold_r      <= ctrl_nxt[CB_P];
    end
  end

  assign out_valid                = out_valid_r;
  assign out_read_data            = out_read_data_r;
  assign out_host_irq             = out_host_irq_r;
  assign out_parasite_irq         = out_para_irq_r;
  assign out_parasite_nmi_pulse   = out_nmi_r;
  assign out_parasite_reset_pulse = out_rst_r;
  assign out_parasite_hold        = out_hold_r;

`ifndef NO_ASSERTIONS
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (a_valid_r && out_valid_r))
    else $error("input stalled with a free pipeline");

  a_desel_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (a_fire && !touched_c) |=> ($stable(ctrl_r) && $stable(hf_r) && $stable(pf_r)))
    else $error("deselected host access changed state");

  a_nmi_level: assert property (@(posedge clk) disable iff (!rst_n)
    (a_fire && nmi_pulse_c) |=> nmi_level_r)
    else $error("nmi pulse without level held");
`endif

endmodule
